// File: design/bsl_pkg.sv
// ----------------------------------------------------------------------------
// bsl_pkg: shared types for the bounded sequential list
// Item layouts on both channels, operation and status codes, the command
// that travels from the front queue to the back engine, and engine states.
// ----------------------------------------------------------------------------
package bsl_pkg;

  localparam int unsigned KEY_W       = 32;
  localparam int unsigned POS_W       = 6;
  localparam int unsigned CNT_OUT_W   = 7;
  localparam int unsigned OP_W        = 2;
  localparam int unsigned STATUS_W    = 3;
  // Depth of the command queue; keep it a power of two.
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_REMOVE = 2'd2,
    OP_READ   = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_BAD_INDEX = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_READ
  } state_e;

  typedef struct packed {
    logic [OP_W-1:0]         op;
    logic signed [KEY_W-1:0] key;
    logic [POS_W-1:0]        index;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]     status;
    logic [POS_W-1:0]        position;
    logic signed [KEY_W-1:0] key_out;
    logic [CNT_OUT_W-1:0]    count;
  } out_item_t;

  typedef struct packed {
    op_e              op;
    logic [KEY_W-1:0] key;
    logic [POS_W-1:0] index;
  } cmd_t;

endpackage

// File: design/bsl_front.sv
// ----------------------------------------------------------------------------
// bsl_front: input decode and command queue
// Accepts items, decodes the operation code and holds the commands in a
// short queue so the input side keeps moving while the engine is busy.
// ----------------------------------------------------------------------------
module bsl_front import bsl_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_item_i,
  output logic     cmd_valid_o,
  input  logic     cmd_ready_i,
  output cmd_t     cmd_o
);

  localparam int unsigned QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t              queue_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] fill_q, fill_d;
  logic              push, pop;
  cmd_t              cmd_dec;

  always_comb begin
    cmd_dec.key   = in_item_i.key;
    cmd_dec.index = in_item_i.index;
    unique case (in_item_i.op)
      OP_INSERT: cmd_dec.op = OP_INSERT;
      OP_SEARCH: cmd_dec.op = OP_SEARCH;
      OP_REMOVE: cmd_dec.op = OP_REMOVE;
      default:   cmd_dec.op = OP_READ;
    endcase
  end

  assign in_ready_o  = (fill_q != QCNT_W'(QUEUE_DEPTH));
  assign cmd_valid_o = (fill_q != '0);
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = queue_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    fill_d   = fill_q;
    if (push && !pop) begin
      fill_d = fill_q + 1'b1;
    end else if (pop && !push) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= cmd_dec;
    end
  end

endmodule

// File: design/bsl_back.sv
// ----------------------------------------------------------------------------
// bsl_back: list engine
// Holds the entry memory and the count, runs one command at a time
// (append, scan for first match, shift-down remove, indexed read) and
// keeps the result in an output register.
// ----------------------------------------------------------------------------
module bsl_back import bsl_pkg::*; #(
  parameter  int unsigned CAPACITY = 64,
  localparam int unsigned IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cmd_valid_i,
  output logic             cmd_ready_o,
  input  cmd_t             cmd_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_item_t        out_item_o,
  output logic [CNT_W-1:0] count_o
);

  localparam int unsigned EXT_W = CNT_W + POS_W + 1;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] lag_ptr_q, lag_ptr_d;
  logic             lag_vld_q, lag_vld_d;
  logic [CNT_W-1:0] pos_q, pos_d;
  cmd_t             cmd_q, cmd_d;
  out_item_t        res_q, res_d;
  logic             res_vld_q, res_vld_d;

  logic [KEY_W-1:0] mem [CAPACITY];
  logic [KEY_W-1:0] rdata_q;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr, mem_raddr;
  logic [KEY_W-1:0] mem_wdata;

  logic             pop, full, empty, idx_ok, issue, hit, last_cmp;
  logic [EXT_W-1:0] idx_ext, cnt_ext;

  function automatic logic [POS_W-1:0] to_pos(input logic [CNT_W-1:0] v);
    logic [EXT_W-1:0] w;
    w = EXT_W'(v);
    return w[POS_W-1:0];
  endfunction

  function automatic logic [CNT_OUT_W-1:0] to_cnt(input logic [CNT_W-1:0] v);
    logic [EXT_W-1:0] w;
    w = EXT_W'(v);
    return w[CNT_OUT_W-1:0];
  endfunction

  assign cmd_ready_o = (state_q == S_IDLE) && !res_vld_q;
  assign pop         = cmd_valid_i && cmd_ready_o;
  assign full        = (count_q == CNT_W'(CAPACITY));
  assign empty       = (count_q == '0);
  assign idx_ext     = EXT_W'(cmd_i.index);
  assign cnt_ext     = EXT_W'(count_q);
  assign idx_ok      = (idx_ext < cnt_ext);
  assign issue       = (rd_ptr_q < count_q);
  assign hit         = lag_vld_q && (rdata_q == cmd_q.key);
  assign last_cmp    = lag_vld_q && ((lag_ptr_q + CNT_W'(1)) == count_q);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (pop) begin
          unique case (cmd_i.op)
            OP_READ:   state_d = idx_ok ? S_READ : S_IDLE;
            OP_SEARCH: state_d = empty ? S_IDLE : S_SCAN;
            OP_REMOVE: state_d = empty ? S_IDLE : S_SCAN;
            default:   state_d = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        if (hit) begin
          state_d = (cmd_q.op == OP_REMOVE) ? S_SHIFT : S_IDLE;
        end else if (last_cmp) begin
          state_d = S_IDLE;
        end
      end
      S_SHIFT: begin
        if (!issue) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    count_d   = count_q;
    rd_ptr_d  = rd_ptr_q;
    lag_ptr_d = rd_ptr_q;
    lag_vld_d = 1'b0;
    pos_d     = pos_q;
    cmd_d     = cmd_q;
    res_d     = res_q;
    res_vld_d = res_vld_q && !out_ready_i;
    mem_we    = 1'b0;
    mem_raddr = rd_ptr_q[IDX_W-1:0];
    mem_waddr = lag_ptr_q[IDX_W-1:0] - 1'b1;
    mem_wdata = rdata_q;
    unique case (state_q)
      S_IDLE: begin
        rd_ptr_d = '0;
        if (pop) begin
          cmd_d = cmd_i;
          res_d = '{status: ST_OK, position: '0, key_out: '0, count: to_cnt(count_q)};
          unique case (cmd_i.op)
            OP_INSERT: begin
              res_vld_d = 1'b1;
              if (full) begin
                res_d.status = ST_FULL;
              end else begin
                mem_we           = 1'b1;
                mem_waddr        = count_q[IDX_W-1:0];
                mem_wdata        = cmd_i.key;
                count_d          = count_q + 1'b1;
                res_d.position   = to_pos(count_q);
                res_d.key_out    = cmd_i.key;
                res_d.count      = to_cnt(count_q + 1'b1);
              end
            end
            OP_SEARCH: begin
              if (empty) begin
                res_vld_d    = 1'b1;
                res_d.status = ST_EMPTY;
              end
            end
            OP_REMOVE: begin
              if (empty) begin
                res_vld_d    = 1'b1;
                res_d.status = ST_NOT_FOUND;
              end
            end
            default: begin
              if (idx_ok) begin
                mem_raddr = idx_ext[IDX_W-1:0];
              end else begin
                res_vld_d    = 1'b1;
                res_d.status = ST_BAD_INDEX;
              end
            end
          endcase
        end
      end
      S_SCAN: begin
        // Read one entry per cycle; compare the previous one as it lands.
        if (issue) begin
          rd_ptr_d  = rd_ptr_q + 1'b1;
          lag_vld_d = 1'b1;
        end
        if (hit) begin
          if (cmd_q.op == OP_REMOVE) begin
            pos_d     = lag_ptr_q;
            rd_ptr_d  = lag_ptr_q + 1'b1;
            lag_vld_d = 1'b0;
          end else begin
            res_vld_d = 1'b1;
            res_d     = '{status: ST_OK, position: to_pos(lag_ptr_q),
                          key_out: cmd_q.key, count: to_cnt(count_q)};
          end
        end else if (last_cmp) begin
          res_vld_d = 1'b1;
          res_d     = '{status: ST_NOT_FOUND, position: '0, key_out: '0,
                        count: to_cnt(count_q)};
        end
      end
      S_SHIFT: begin
        // Read entry i+1 now, write it to entry i in the next cycle.
        mem_we = lag_vld_q;
        if (issue) begin
          rd_ptr_d  = rd_ptr_q + 1'b1;
          lag_vld_d = 1'b1;
        end else begin
          count_d   = count_q - 1'b1;
          res_vld_d = 1'b1;
          res_d     = '{status: ST_OK, position: to_pos(pos_q),
                        key_out: cmd_q.key, count: to_cnt(count_q - 1'b1)};
        end
      end
      default: begin
        res_vld_d = 1'b1;
        res_d     = '{status: ST_OK, position: cmd_q.index, key_out: rdata_q,
                      count: to_cnt(count_q)};
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      rd_ptr_q  <= '0;
      lag_ptr_q <= '0;
      lag_vld_q <= 1'b0;
      pos_q     <= '0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      rd_ptr_q  <= rd_ptr_d;
      lag_ptr_q <= lag_ptr_d;
      lag_vld_q <= lag_vld_d;
      pos_q     <= pos_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    res_q <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[mem_raddr];
  end

  assign out_valid_o = res_vld_q;
  assign out_item_o  = res_q;
  assign count_o     = count_q;

endmodule

// File: design/bounded_sequential_list.sv
// ----------------------------------------------------------------------------
// bounded_sequential_list: fixed-capacity ordered list of signed keys
// Top level: command queue in front, list engine with entry memory behind.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_item_i) takes one operation
//   per item: insert, search, remove or read at index. Output channel
//   (out_valid_o / out_ready_i / out_item_o) returns exactly one result per
//   item, in order, with status, position, key and the count afterwards.
//   Insert, read and any early reject are answered without a walk; search
//   and remove walk the entry memory one entry per cycle through its single
//   read port: search scans to the first match or the end, and remove scans
//   to the match, then shifts the later entries down one per cycle. The
//   engine takes no new item until the last result has been taken; the
//   queue holds QUEUE_DEPTH items meanwhile.
//   Reset clears the count and the queue; the list is empty afterwards and
//   no memory clearing pass is needed. While the receiver stalls the result
//   holds in the output register and the engine takes no new command; the
//   queue keeps accepting items until it fills.
// ----------------------------------------------------------------------------
module bounded_sequential_list import bsl_pkg::*; #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  logic             cmd_valid;
  logic             cmd_ready;
  cmd_t             cmd;
  logic [CNT_W-1:0] count_w;

  bsl_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  bsl_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .count_o     (count_w)
  );

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_w <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_full_means_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_item_o.status == ST_FULL)) |-> (count_w == CNT_W'(CAPACITY)))
    else $error("full reported with room left");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_w != $past(count_w)) |->
      ((count_w == $past(count_w) + 1'b1) || ($past(count_w) == count_w + 1'b1)))
    else $error("entry count moved by more than one");
`endif

endmodule
